// ===== rtl/psp_pkg.sv =====
// Shared types and constants for the particle slot pool.
`default_nettype none
package psp_pkg;

   localparam int POOL_SLOTS = 32;
   localparam int SLOT_W     = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
   localparam int CNT_CMP_W  = 7;
   localparam int LIFE_W     = 16;
   localparam int POS_W      = 16;
   localparam int TINT_W     = 32;
   localparam int OUT_SLOT_W = 6;
   localparam int CNT_W      = 6;
   localparam int DEC_W      = 24;
   localparam int PROD_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_LIFE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_RATE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOTS_IN_USE = 2'd2;

   localparam logic [LIFE_W-1:0] INITIAL_LIFE_RST = 16'd256;
   localparam logic [LIFE_W-1:0] DECAY_RATE_RST   = 16'd256;
   localparam logic [CNT_W-1:0]  SLOTS_RST        = 6'd32;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_TICK  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_LIST  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT,
      ST_ADD_DONE,
      ST_ACK
   } state_type;

   typedef struct packed {
      logic                     en;
      logic [SLOT_W-1:0]        idx;
      logic [LIFE_W-1:0]        life;
      logic                     part;
      logic [POS_W-1:0]         x;
      logic [POS_W-1:0]         y;
      logic [TINT_W-1:0]        tint;
   } wr_type;

   typedef struct packed {
      logic                     en;
      logic [SLOT_W-1:0]        last;
   } clr_type;

   typedef struct packed {
      logic [LIFE_W-1:0]        life;
      logic [POS_W-1:0]         x;
      logic [POS_W-1:0]         y;
      logic [TINT_W-1:0]        tint;
   } rd_type;

endpackage
`default_nettype wire

// ===== rtl/psp_store.sv =====
// Slot storage: life, position and color memories with per-slot live bits.
`default_nettype none
module psp_store (
   input  wire                          clock,
   input  wire                          reset,
   input  wire psp_pkg::wr_type         wr,
   input  wire psp_pkg::clr_type        clr,
   input  wire                          rd_en,
   input  wire [psp_pkg::SLOT_W-1:0]    rd_idx,
   output psp_pkg::rd_type              rd
);

   logic [psp_pkg::LIFE_W-1:0] life_mem [psp_pkg::POOL_SLOTS];
   logic [psp_pkg::POS_W-1:0]  x_mem    [psp_pkg::POOL_SLOTS];
   logic [psp_pkg::POS_W-1:0]  y_mem    [psp_pkg::POOL_SLOTS];
   logic [psp_pkg::TINT_W-1:0] tint_mem [psp_pkg::POOL_SLOTS];

   logic [psp_pkg::POOL_SLOTS-1:0] vld_ff;
   logic [psp_pkg::POOL_SLOTS-1:0] vld_in;

   logic                       lv_rd_ff;
   logic [psp_pkg::LIFE_W-1:0] life_rd_ff;
   logic [psp_pkg::POS_W-1:0]  x_rd_ff;
   logic [psp_pkg::POS_W-1:0]  y_rd_ff;
   logic [psp_pkg::TINT_W-1:0] tint_rd_ff;

   always_comb begin
      vld_in = vld_ff;
      if (clr.en) begin
         for (int i = 0; i < psp_pkg::POOL_SLOTS; i++) begin
            if (psp_pkg::SLOT_W'(i) <= clr.last) begin
               vld_in[i] = 1'b0;
            end
         end
      end
      if (wr.en) begin
         vld_in[wr.idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         life_mem[wr.idx] <= wr.life;
      end
      if (wr.en && wr.part) begin
         x_mem[wr.idx]    <= wr.x;
         y_mem[wr.idx]    <= wr.y;
         tint_mem[wr.idx] <= wr.tint;
      end
      if (rd_en) begin
         lv_rd_ff   <= vld_ff[rd_idx];
         life_rd_ff <= life_mem[rd_idx];
         x_rd_ff    <= x_mem[rd_idx];
         y_rd_ff    <= y_mem[rd_idx];
         tint_rd_ff <= tint_mem[rd_idx];
      end
   end

   // a slot never written since reset or clear reads as dead
   assign rd.life = lv_rd_ff ? life_rd_ff : '0;
   assign rd.x    = x_rd_ff;
   assign rd.y    = y_rd_ff;
   assign rd.tint = tint_rd_ff;

endmodule
`default_nettype wire

// ===== rtl/particle_slot_pool_with_life_decay.sv =====
// Particle slot pool: top level with scan sequencer and result register.
//
// Request beats (req_valid/req_stall) carry an operation: add, tick, clear or
// list. One request is worked on at a time; req_stall is high from the cycle
// after acceptance until the sequencer is back in idle. Results leave through
// a single result register (rsp_valid/rsp_stall), so a new request is taken
// while the previous final result is still waiting.
// With n active slots, add and tick scan the slot memory once through its
// single registered read port, one slot per cycle. Clear resets the live bits
// of all active slots at acceptance and then acknowledges. List scans once to
// find the last live slot and, if any slot is live, again to report; otherwise
// it acknowledges. A stalled result holds the report scan.
// Add, tick and clear hold their final step while an earlier result is stalled.
// Configuration (csr_wr_en, csr_index, csr_wdata) must be written only while
// idle; the block itself does not enforce it.
// Synchronous reset empties the result register, returns to idle, marks all
// slots dead and loads the register reset values; no clearing pass is needed.
`default_nettype none
module particle_slot_pool_with_life_decay (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire  [1:0]                         req_operation,
   input  wire  signed [psp_pkg::POS_W-1:0]   req_pos_x,
   input  wire  signed [psp_pkg::POS_W-1:0]   req_pos_y,
   input  wire  [psp_pkg::TINT_W-1:0]         req_tint,
   input  wire  [psp_pkg::LIFE_W-1:0]         req_elapsed,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic [psp_pkg::OUT_SLOT_W-1:0]     rsp_slot,
   output logic [psp_pkg::LIFE_W-1:0]         rsp_remaining_life,
   output logic signed [psp_pkg::POS_W-1:0]   rsp_out_x,
   output logic signed [psp_pkg::POS_W-1:0]   rsp_out_y,
   output logic [psp_pkg::TINT_W-1:0]         rsp_out_tint,
   output logic                               rsp_entry_valid,
   output logic                               rsp_evicted,
   output logic                               rsp_last,
   input  wire                                csr_wr_en,
   input  wire  [psp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [psp_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   psp_pkg::state_type                 state_ff, state_in;
   psp_pkg::op_type                    op_ff, op_in;
   logic [psp_pkg::LIFE_W-1:0]         init_life_ff, init_life_in;
   logic [psp_pkg::LIFE_W-1:0]         rate_ff, rate_in;
   logic [psp_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [psp_pkg::POS_W-1:0]          x_ff, x_in, y_ff, y_in;
   logic [psp_pkg::TINT_W-1:0]         tint_ff, tint_in;
   logic [psp_pkg::DEC_W-1:0]          dec_ff, dec_in;
   logic [psp_pkg::SLOT_W-1:0]         idx_ff, idx_in;
   logic                               iss_ff, iss_in;
   logic                               pb_ff, pb_in;
   logic [psp_pkg::SLOT_W-1:0]         pb_idx_ff, pb_idx_in;
   logic [psp_pkg::SLOT_W-1:0]         best_idx_ff, best_idx_in;
   logic [psp_pkg::LIFE_W-1:0]         best_life_ff, best_life_in;
   logic                               found_ff, found_in;
   logic [psp_pkg::SLOT_W-1:0]         last_live_ff, last_live_in;
   logic                               any_ff, any_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [psp_pkg::OUT_SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [psp_pkg::LIFE_W-1:0]         rsp_life_ff, rsp_life_in;
   logic [psp_pkg::POS_W-1:0]          rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [psp_pkg::TINT_W-1:0]         rsp_tint_ff, rsp_tint_in;
   logic                               rsp_ev_ff, rsp_ev_in;
   logic                               rsp_ent_ff, rsp_ent_in;
   logic                               rsp_last_ff, rsp_last_in;

   psp_pkg::wr_type                    wr;
   psp_pkg::clr_type                   clr;
   psp_pkg::rd_type                    rd;
   logic                               rd_en;

   logic [psp_pkg::SLOT_W-1:0]         active_last;
   logic [psp_pkg::PROD_W-1:0]         prod;
   logic                               accept;
   logic                               out_free;
   logic                               hold;
   logic                               adv;
   logic                               live;

   psp_store u_store (
      .clock  (clock),
      .reset  (reset),
      .wr     (wr),
      .clr    (clr),
      .rd_en  (rd_en),
      .rd_idx (idx_ff),
      .rd     (rd)
   );

   always_comb begin
      if (count_ff == '0) begin
         active_last = '0;
      end else if ({1'b0, count_ff} > psp_pkg::CNT_CMP_W'(psp_pkg::POOL_SLOTS)) begin
         active_last = psp_pkg::SLOT_W'(psp_pkg::POOL_SLOTS - 1);
      end else begin
         active_last = psp_pkg::SLOT_W'(count_ff - 1'b1);
      end
   end

   assign prod      = psp_pkg::PROD_W'(rate_ff) * psp_pkg::PROD_W'(req_elapsed);
   assign req_stall = (state_ff != psp_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign live      = (rd.life != '0);
   assign hold      = (state_ff == psp_pkg::ST_EMIT) && pb_ff && live && !out_free;
   assign adv       = ((state_ff == psp_pkg::ST_SCAN) || (state_ff == psp_pkg::ST_EMIT))
                      && !hold;
   assign rd_en     = adv && iss_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      init_life_in = init_life_ff;
      rate_in      = rate_ff;
      count_in     = count_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      tint_in      = tint_ff;
      dec_in       = dec_ff;
      idx_in       = idx_ff;
      iss_in       = iss_ff;
      pb_in        = pb_ff;
      pb_idx_in    = pb_idx_ff;
      best_idx_in  = best_idx_ff;
      best_life_in = best_life_ff;
      found_in     = found_ff;
      last_live_in = last_live_ff;
      any_in       = any_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_slot_in  = rsp_slot_ff;
      rsp_life_in  = rsp_life_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_tint_in  = rsp_tint_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_ent_in   = rsp_ent_ff;
      rsp_last_in  = rsp_last_ff;
      wr           = '0;
      clr          = '0;

      if (csr_wr_en) begin
         case (csr_index)
            psp_pkg::CSR_INITIAL_LIFE: init_life_in = csr_wdata;
            psp_pkg::CSR_DECAY_RATE:   rate_in      = csr_wdata;
            psp_pkg::CSR_SLOTS_IN_USE: count_in     = csr_wdata[psp_pkg::CNT_W-1:0];
            default: ;
         endcase
      end

      // scan pipeline: read issue stage, then evaluate stage
      if (adv) begin
         if (iss_ff) begin
            pb_in     = 1'b1;
            pb_idx_in = idx_ff;
            if (idx_ff == active_last) begin
               iss_in = 1'b0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end else begin
            pb_in = 1'b0;
         end
      end

      case (state_ff)
         psp_pkg::ST_IDLE: begin
            if (accept) begin
               op_in    = psp_pkg::op_type'(req_operation);
               x_in     = req_pos_x;
               y_in     = req_pos_y;
               tint_in  = req_tint;
               dec_in   = prod[psp_pkg::PROD_W-1:8];
               idx_in   = '0;
               iss_in   = 1'b1;
               pb_in    = 1'b0;
               found_in = 1'b0;
               any_in   = 1'b0;
               if (psp_pkg::op_type'(req_operation) == psp_pkg::OP_CLEAR) begin
                  clr.en   = 1'b1;
                  clr.last = active_last;
                  state_in = psp_pkg::ST_ACK;
               end else begin
                  state_in = psp_pkg::ST_SCAN;
               end
            end
         end
         psp_pkg::ST_SCAN: begin
            if (pb_ff) begin
               case (op_ff)
                  psp_pkg::OP_ADD: begin
                     if (pb_idx_ff == '0) begin
                        best_idx_in  = '0;
                        best_life_in = rd.life;
                     end else if (!found_ff) begin
                        if (!live) begin
                           found_in     = 1'b1;
                           best_idx_in  = pb_idx_ff;
                           best_life_in = '0;
                        end else if (rd.life < best_life_ff) begin
                           best_idx_in  = pb_idx_ff;
                           best_life_in = rd.life;
                        end
                     end
                  end
                  psp_pkg::OP_TICK: begin
                     if (live) begin
                        wr.en  = 1'b1;
                        wr.idx = pb_idx_ff;
                        wr.life = (psp_pkg::DEC_W'(rd.life) > dec_ff) ?
                                  (rd.life - dec_ff[psp_pkg::LIFE_W-1:0]) : '0;
                     end
                  end
                  psp_pkg::OP_LIST: begin
                     if (live) begin
                        last_live_in = pb_idx_ff;
                        any_in       = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            if (!iss_ff && !pb_ff) begin
               case (op_ff)
                  psp_pkg::OP_ADD:  state_in = psp_pkg::ST_ADD_DONE;
                  psp_pkg::OP_LIST: begin
                     if (any_ff) begin
                        state_in = psp_pkg::ST_EMIT;
                        idx_in   = '0;
                        iss_in   = 1'b1;
                     end else begin
                        state_in = psp_pkg::ST_ACK;
                     end
                  end
                  default: state_in = psp_pkg::ST_ACK;
               endcase
            end
         end
         psp_pkg::ST_EMIT: begin
            if (pb_ff && live && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = psp_pkg::OUT_SLOT_W'(pb_idx_ff);
               rsp_life_in  = rd.life;
               rsp_x_in     = rd.x;
               rsp_y_in     = rd.y;
               rsp_tint_in  = rd.tint;
               rsp_ent_in   = 1'b1;
               rsp_ev_in    = 1'b0;
               rsp_last_in  = (pb_idx_ff == last_live_ff);
            end
            if (!iss_ff && !pb_ff) begin
               state_in = psp_pkg::ST_IDLE;
            end
         end
         psp_pkg::ST_ADD_DONE: begin
            if (out_free) begin
               wr.en        = 1'b1;
               wr.idx       = best_idx_ff;
               wr.life      = init_life_ff;
               wr.part      = 1'b1;
               wr.x         = x_ff;
               wr.y         = y_ff;
               wr.tint      = tint_ff;
               rsp_valid_in = 1'b1;
               rsp_slot_in  = psp_pkg::OUT_SLOT_W'(best_idx_ff);
               rsp_life_in  = init_life_ff;
               rsp_x_in     = x_ff;
               rsp_y_in     = y_ff;
               rsp_tint_in  = tint_ff;
               rsp_ent_in   = 1'b1;
               rsp_ev_in    = (best_life_ff != '0);
               rsp_last_in  = 1'b1;
               state_in     = psp_pkg::ST_IDLE;
            end
         end
         psp_pkg::ST_ACK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = '0;
               rsp_life_in  = '0;
               rsp_x_in     = '0;
               rsp_y_in     = '0;
               rsp_tint_in  = '0;
               rsp_ent_in   = 1'b0;
               rsp_ev_in    = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = psp_pkg::ST_IDLE;
            end
         end
         default: state_in = psp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psp_pkg::ST_IDLE;
         init_life_ff <= psp_pkg::INITIAL_LIFE_RST;
         rate_ff      <= psp_pkg::DECAY_RATE_RST;
         count_ff     <= psp_pkg::SLOTS_RST;
         iss_ff       <= 1'b0;
         pb_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_life_ff <= init_life_in;
         rate_ff      <= rate_in;
         count_ff     <= count_in;
         iss_ff       <= iss_in;
         pb_ff        <= pb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      tint_ff      <= tint_in;
      dec_ff       <= dec_in;
      idx_ff       <= idx_in;
      pb_idx_ff    <= pb_idx_in;
      best_idx_ff  <= best_idx_in;
      best_life_ff <= best_life_in;
      found_ff     <= found_in;
      last_live_ff <= last_live_in;
      any_ff       <= any_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_life_ff  <= rsp_life_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_tint_ff  <= rsp_tint_in;
      rsp_ev_ff    <= rsp_ev_in;
      rsp_ent_ff   <= rsp_ent_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_remaining_life = rsp_life_ff;
   assign rsp_out_x          = rsp_x_ff;
   assign rsp_out_y          = rsp_y_ff;
   assign rsp_out_tint       = rsp_tint_ff;
   assign rsp_entry_valid    = rsp_ent_ff;
   assign rsp_evicted        = rsp_ev_ff;
   assign rsp_last           = rsp_last_ff;

endmodule
`default_nettype wire

// ===== rtl/psp_chk.sv =====
// Port-level assertion checker for the particle slot pool, with its bind.
`default_nettype none
module psp_chk (
   input wire                               clock,
   input wire                               reset,
   input wire                               req_valid,
   input wire                               req_stall,
   input wire                               rsp_valid,
   input wire                               rsp_stall,
   input wire [psp_pkg::OUT_SLOT_W-1:0]     rsp_slot,
   input wire [psp_pkg::LIFE_W-1:0]         rsp_remaining_life,
   input wire                               rsp_entry_valid,
   input wire                               rsp_evicted,
   input wire                               rsp_last
);

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat present after reset");

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_slot) && $stable(rsp_last)
      && $stable(rsp_remaining_life) && $stable(rsp_entry_valid))
      else $error("stalled result beat changed");

   // one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // acknowledge beats are all zero and final
   a_ack_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_entry_valid |-> rsp_last && !rsp_evicted
      && (rsp_slot == '0) && (rsp_remaining_life == '0))
      else $error("malformed acknowledge beat");

   // eviction only on an add result, inside the pool
   a_evict_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> rsp_entry_valid && rsp_last
      && (rsp_slot < psp_pkg::OUT_SLOT_W'(psp_pkg::POOL_SLOTS)))
      else $error("malformed eviction beat");

endmodule

bind particle_slot_pool_with_life_decay psp_chk u_psp_chk (.*);
`default_nettype wire
